FILE: hw/rtl/uotdf_pkg.sv
// ----------------------------------------------------------------------------
// uotdf_pkg: shared types and codes for the stream deframer
// Address type codes for the handshake and packet headers, byte roles,
// address kinds and error codes.
// ----------------------------------------------------------------------------
package uotdf_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [1:0] role_t;
  typedef logic [1:0] kind_t;
  typedef logic [1:0] err_t;

  // byte roles
  localparam role_t ROLE_CTRL = 2'd0;
  localparam role_t ROLE_ADDR = 2'd1;
  localparam role_t ROLE_DATA = 2'd2;

  // address kinds
  localparam kind_t KIND_V4  = 2'd0;
  localparam kind_t KIND_V6  = 2'd1;
  localparam kind_t KIND_DOM = 2'd2;

  // error codes
  localparam err_t ERR_NONE     = 2'd0;
  localparam err_t ERR_HS_TYPE  = 2'd1;
  localparam err_t ERR_PKT_TYPE = 2'd2;
  localparam err_t ERR_EMPTY    = 2'd3;

  // handshake address type bytes
  localparam byte_t HS_ATYPE_V4  = 8'h01;
  localparam byte_t HS_ATYPE_V6  = 8'h04;
  localparam byte_t HS_ATYPE_DOM = 8'h03;

  // per-packet address type bytes
  localparam byte_t PKT_ATYPE_V4  = 8'h00;
  localparam byte_t PKT_ATYPE_V6  = 8'h01;
  localparam byte_t PKT_ATYPE_DOM = 8'h02;

  // address sizes in bytes
  localparam byte_t V4_BYTES = 8'd4;
  localparam byte_t V6_BYTES = 8'd16;

  // ipv4-mapped ipv6 prefix: ten zero bytes, then two 0xff bytes
  localparam logic [15:0] MAP_ZERO_END = 16'd10;
  localparam logic [15:0] MAP_FF_END   = 16'd12;
  localparam byte_t       MAP_FF_BYTE  = 8'hff;

endpackage

FILE: hw/rtl/uot_stream_deframer.sv
// ----------------------------------------------------------------------------
// uot_stream_deframer: udp-over-tcp stream deframer
// Takes the tunnel stream one byte per item. Parses the handshake (connect
// flag, socks address, port) and then the data frames (optional per-packet
// address and port, 16-bit length, payload). Each byte gives one result item
// that tags its role and echoes address and payload bytes.
//
// Usage:
//   item channel: item_valid/item_ready with in_byte.
//   result channel: res_valid/res_ready with the result fields.
//   A byte taken shows its result in the next cycle. Throughput is one byte
//   per clock unless the receiver stalls; all parsing is a single layer
//   of logic between the parser state registers and the result register.
//   A finished result waits in the result register while the receiver
//   stalls; item_ready stays high as long as that register is empty or is
//   being drained in the same cycle, so a stall of the receiver stalls the
//   sender by exactly one register.
//   Reset (rst, synchronous) empties the result register and puts the parser
//   back to the connect flag byte of the handshake with all fields cleared.
//   After a bad address type or an empty domain the error sticks until reset;
//   later bytes still produce results, with accepted low.
// ----------------------------------------------------------------------------
module uot_stream_deframer (
  input  logic                  clk,
  input  logic                  rst,
  // item channel
  input  logic                  item_valid,
  output logic                  item_ready,
  input  uotdf_pkg::byte_t      in_byte,
  // result channel
  output logic                  res_valid,
  input  logic                  res_ready,
  output logic                  accepted,
  output uotdf_pkg::role_t      byte_role,
  output uotdf_pkg::byte_t      pass_byte,
  output uotdf_pkg::kind_t      addr_kind,
  output logic                  addr_mapped_v4,
  output logic                  connect_mode,
  output logic [15:0]           dest_port,
  output logic [15:0]           frame_length,
  output logic                  frame_done,
  output logic                  handshake_part,
  output uotdf_pkg::err_t       error_code
);

  import uotdf_pkg::*;

  typedef enum logic [3:0] {
    ST_HS_CONN,
    ST_HS_ATYPE,
    ST_HS_ADDR,
    ST_HS_DLEN,
    ST_HS_DOM,
    ST_HS_PORT,
    ST_D_LEN1,
    ST_D_LEN2,
    ST_D_DATA,
    ST_D_ADDR,
    ST_D_DLEN,
    ST_D_DOM,
    ST_D_PORT
  } state_t;

  // parser state
  state_t      state, state_next;
  logic [15:0] fcount, fcount_next;
  byte_t       fneed, fneed_next;
  logic        conn, conn_next;
  logic        pseen, pseen_next;
  logic        sticky, sticky_next;
  err_t        err_reg, err_reg_next;
  logic [15:0] port, port_next;
  logic [15:0] len, len_next;
  logic        mtrack, mtrack_next;
  kind_t       kind, kind_next;

  // per-byte result
  logic        r_acc, r_mapped, r_done, r_hs;
  role_t       r_role;
  byte_t       r_pass;
  err_t        r_err;

  logic        take;
  logic        do_atype;
  logic        atype_hs;
  logic [15:0] count_inc;
  byte_t       c4, c6, cd;

  assign take      = item_valid && item_ready;
  assign item_ready = !res_valid || res_ready;
  assign count_inc = fcount + 16'd1;
  assign atype_hs  = (state == ST_HS_ATYPE);
  assign c4 = atype_hs ? HS_ATYPE_V4  : PKT_ATYPE_V4;
  assign c6 = atype_hs ? HS_ATYPE_V6  : PKT_ATYPE_V6;
  assign cd = atype_hs ? HS_ATYPE_DOM : PKT_ATYPE_DOM;

  // parse one byte
  always_comb begin
    state_next   = state;
    fcount_next  = fcount;
    fneed_next   = fneed;
    conn_next    = conn;
    pseen_next   = pseen;
    sticky_next  = sticky;
    err_reg_next = err_reg;
    port_next    = port;
    len_next     = len;
    mtrack_next  = mtrack;
    kind_next    = kind;
    r_acc    = 1'b1;
    r_role   = ROLE_CTRL;
    r_pass   = '0;
    r_mapped = 1'b0;
    r_done   = 1'b0;
    r_hs     = 1'b0;
    r_err    = ERR_NONE;
    do_atype = 1'b0;

    if (sticky) begin
      r_acc = 1'b0;
      r_err = err_reg;
    end else begin
      case (state)
        ST_HS_ATYPE: begin
          r_hs     = 1'b1;
          do_atype = 1'b1;
        end
        ST_HS_ADDR, ST_D_ADDR: begin
          r_hs   = (state == ST_HS_ADDR);
          r_role = ROLE_ADDR;
          r_pass = in_byte;
          if (kind == KIND_V6) begin
            if (fcount < MAP_ZERO_END) begin
              if (in_byte != 8'h00) mtrack_next = 1'b0;
            end else if (fcount < MAP_FF_END) begin
              if (in_byte != MAP_FF_BYTE) mtrack_next = 1'b0;
            end
          end
          fcount_next = count_inc;
          if (count_inc >= {8'h00, fneed}) begin
            if (kind == KIND_V6) r_mapped = mtrack_next;
            fcount_next = '0;
            fneed_next  = '0;
            state_next  = (state == ST_HS_ADDR) ? ST_HS_PORT : ST_D_PORT;
          end
        end
        ST_HS_DLEN, ST_D_DLEN: begin
          r_hs = (state == ST_HS_DLEN);
          if (in_byte == 8'h00) begin
            sticky_next  = 1'b1;
            err_reg_next = ERR_EMPTY;
            r_err        = ERR_EMPTY;
          end else begin
            fneed_next  = in_byte;
            fcount_next = '0;
            state_next  = (state == ST_HS_DLEN) ? ST_HS_DOM : ST_D_DOM;
          end
        end
        ST_HS_DOM, ST_D_DOM: begin
          r_hs   = (state == ST_HS_DOM);
          r_role = ROLE_ADDR;
          r_pass = in_byte;
          fcount_next = count_inc;
          if (count_inc >= {8'h00, fneed}) begin
            fcount_next = '0;
            fneed_next  = '0;
            state_next  = (state == ST_HS_DOM) ? ST_HS_PORT : ST_D_PORT;
          end
        end
        ST_HS_PORT, ST_D_PORT: begin
          r_hs = (state == ST_HS_PORT);
          if (fcount == 16'd0) begin
            fneed_next  = in_byte;
            fcount_next = 16'd1;
          end else begin
            port_next   = {fneed, in_byte};
            fcount_next = '0;
            fneed_next  = '0;
            if (state == ST_HS_PORT) r_done = 1'b1;
            else pseen_next = 1'b1;
            state_next = ST_D_LEN1;
          end
        end
        ST_D_LEN1: begin
          if (!conn && !pseen) begin
            do_atype = 1'b1;
          end else begin
            len_next   = {in_byte, 8'h00};
            state_next = ST_D_LEN2;
          end
        end
        ST_D_LEN2: begin
          len_next    = len | {8'h00, in_byte};
          fcount_next = '0;
          fneed_next  = '0;
          if (len_next == 16'd0) begin
            r_done     = 1'b1;
            pseen_next = 1'b0;
            state_next = ST_D_LEN1;
          end else begin
            state_next = ST_D_DATA;
          end
        end
        ST_D_DATA: begin
          r_role = ROLE_DATA;
          r_pass = in_byte;
          fcount_next = count_inc;
          if (count_inc >= len) begin
            r_done      = 1'b1;
            pseen_next  = 1'b0;
            fcount_next = '0;
            state_next  = ST_D_LEN1;
          end
        end
        default: begin
          r_hs        = 1'b1;
          conn_next   = (in_byte != 8'h00);
          fcount_next = '0;
          fneed_next  = '0;
          state_next  = ST_HS_ATYPE;
        end
      endcase

      // address type byte, handshake or per-packet
      if (do_atype) begin
        fcount_next = '0;
        fneed_next  = '0;
        mtrack_next = 1'b1;
        if (in_byte == c4) begin
          kind_next  = KIND_V4;
          fneed_next = V4_BYTES;
          state_next = atype_hs ? ST_HS_ADDR : ST_D_ADDR;
        end else if (in_byte == c6) begin
          kind_next  = KIND_V6;
          fneed_next = V6_BYTES;
          state_next = atype_hs ? ST_HS_ADDR : ST_D_ADDR;
        end else if (in_byte == cd) begin
          kind_next  = KIND_DOM;
          state_next = atype_hs ? ST_HS_DLEN : ST_D_DLEN;
        end else begin
          sticky_next  = 1'b1;
          err_reg_next = atype_hs ? ERR_HS_TYPE : ERR_PKT_TYPE;
          r_err        = err_reg_next;
        end
      end
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_HS_CONN;
      fcount  <= '0;
      fneed   <= '0;
      conn    <= 1'b0;
      pseen   <= 1'b0;
      sticky  <= 1'b0;
      err_reg <= ERR_NONE;
      port    <= '0;
      len     <= '0;
      mtrack  <= 1'b1;
      kind    <= KIND_V4;
    end else if (take) begin
      state   <= state_next;
      fcount  <= fcount_next;
      fneed   <= fneed_next;
      conn    <= conn_next;
      pseen   <= pseen_next;
      sticky  <= sticky_next;
      err_reg <= err_reg_next;
      port    <= port_next;
      len     <= len_next;
      mtrack  <= mtrack_next;
      kind    <= kind_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (take) begin
      accepted       <= r_acc;
      byte_role      <= r_role;
      pass_byte      <= r_pass;
      addr_kind      <= kind_next;
      addr_mapped_v4 <= r_mapped;
      connect_mode   <= conn_next;
      dest_port      <= port_next;
      frame_length   <= len_next;
      frame_done     <= r_done;
      handshake_part <= r_hs;
      error_code     <= r_err;
    end
  end

  // the error never clears without reset
  a_sticky_holds: assert property (@(posedge clk) disable iff (rst)
    sticky |=> sticky)
    else $error("sticky error cleared");

  // a byte that is not consumed always carries an error code
  a_refused_has_err: assert property (@(posedge clk) disable iff (rst)
    res_valid && !accepted |-> error_code != ERR_NONE)
    else $error("refused byte without error code");

  // the mapped flag only marks an ipv6 address byte
  a_mapped_v6: assert property (@(posedge clk) disable iff (rst)
    res_valid && addr_mapped_v4 |-> addr_kind == KIND_V6 && byte_role == ROLE_ADDR)
    else $error("mapped flag outside ipv6 address");

  // a full result register that is not drained blocks new items
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |-> !item_ready)
    else $error("item taken while result stalled");

endmodule

FILE: verif/tb_uot_stream_deframer.sv
// ----------------------------------------------------------------------------
// tb_uot_stream_deframer: self-checking bench for the stream deframer
// Feeds a handshake and then well-formed data frames with random addresses,
// ports, lengths and payload, under several idle and stall patterns with one
// long receiver hold-off; without connect it ends with a sticky error. A
// behavioral parser in the bench predicts every result item, and a checker
// compares each one as it leaves the block.
// ----------------------------------------------------------------------------
module tb_uot_stream_deframer;
  import uotdf_pkg::*;

  localparam int HOLD_CYCLES = 200;
  localparam int QUIET_LIMIT = 4000;

  // parser states of the bench model
  typedef enum logic [4:0] {
    PS_CONN, PS_HS_ATYPE, PS_HS_ADDR, PS_HS_DLEN, PS_HS_DOM, PS_HS_PORT,
    PS_LEN_HI, PS_LEN_LO, PS_DATA, PS_PKT_ADDR, PS_PKT_DLEN, PS_PKT_DOM,
    PS_PKT_PORT
  } parse_e;

  typedef struct {
    logic        accepted;
    role_t       byte_role;
    byte_t       pass_byte;
    kind_t       addr_kind;
    logic        addr_mapped_v4;
    logic        connect_mode;
    logic [15:0] dest_port;
    logic [15:0] frame_length;
    logic        frame_done;
    logic        handshake_part;
    err_t        error_code;
  } deframe_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  byte_t       in_byte = 8'h00;
  logic        res_valid;
  logic        res_ready = 1'b0;
  logic        accepted;
  role_t       byte_role;
  byte_t       pass_byte;
  kind_t       addr_kind;
  logic        addr_mapped_v4;
  logic        connect_mode;
  logic [15:0] dest_port;
  logic [15:0] frame_length;
  logic        frame_done;
  logic        handshake_part;
  err_t        error_code;

  // parser model state
  parse_e      ps = PS_CONN;
  logic [15:0] fld_cnt = 16'h0;
  byte_t       fld_need = 8'h00;
  logic        conn_flag = 1'b0;
  logic        pkt_addr_seen = 1'b0;
  logic        err_latched = 1'b0;
  err_t        err_code = ERR_NONE;
  logic [15:0] port_q = 16'h0;
  logic [15:0] len_q = 16'h0;
  logic        map_ok = 1'b1;
  kind_t       kind_q = KIND_V4;

  deframe_res_t pending_results[$];
  int unsigned  mismatches = 0;
  int unsigned  items_sent = 0;
  int unsigned  idle_pct = 0;
  int unsigned  stall_pct = 0;
  int unsigned  quiet_cycles = 0;
  logic         hold_req = 1'b0;
  bit           gen_conn = 1'b0;

  uot_stream_deframer dut (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .in_byte        (in_byte),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .accepted       (accepted),
    .byte_role      (byte_role),
    .pass_byte      (pass_byte),
    .addr_kind      (addr_kind),
    .addr_mapped_v4 (addr_mapped_v4),
    .connect_mode   (connect_mode),
    .dest_port      (dest_port),
    .frame_length   (frame_length),
    .frame_done     (frame_done),
    .handshake_part (handshake_part),
    .error_code     (error_code)
  );

  always #1 clk = ~clk;

  // address type byte, shared by handshake and packet headers
  function automatic err_t take_addr_type(byte_t b, logic hs);
    byte_t c4, c6, cd;
    c4 = hs ? HS_ATYPE_V4  : PKT_ATYPE_V4;
    c6 = hs ? HS_ATYPE_V6  : PKT_ATYPE_V6;
    cd = hs ? HS_ATYPE_DOM : PKT_ATYPE_DOM;
    fld_cnt = 16'h0;
    fld_need = 8'h00;
    map_ok = 1'b1;
    if (b == c4) begin
      kind_q = KIND_V4;
      fld_need = V4_BYTES;
      ps = hs ? PS_HS_ADDR : PS_PKT_ADDR;
    end else if (b == c6) begin
      kind_q = KIND_V6;
      fld_need = V6_BYTES;
      ps = hs ? PS_HS_ADDR : PS_PKT_ADDR;
    end else if (b == cd) begin
      kind_q = KIND_DOM;
      ps = hs ? PS_HS_DLEN : PS_PKT_DLEN;
    end else begin
      // unknown type: kind stays as it was
      err_latched = 1'b1;
      err_code = hs ? ERR_HS_TYPE : ERR_PKT_TYPE;
      return err_code;
    end
    return ERR_NONE;
  endfunction

  // advance the parser model by one stream byte
  function automatic deframe_res_t deframe_byte(byte_t b);
    deframe_res_t r;
    logic on_hs;
    r = '{accepted: 1'b1, byte_role: ROLE_CTRL, pass_byte: 8'h00,
          addr_kind: KIND_V4, addr_mapped_v4: 1'b0, connect_mode: 1'b0,
          dest_port: 16'h0, frame_length: 16'h0, frame_done: 1'b0,
          handshake_part: 1'b0, error_code: ERR_NONE};
    if (err_latched) begin
      r.accepted = 1'b0;
      r.error_code = err_code;
    end else begin
      case (ps)
        PS_HS_ATYPE: begin
          r.handshake_part = 1'b1;
          r.error_code = take_addr_type(b, 1'b1);
        end
        PS_HS_ADDR, PS_PKT_ADDR: begin
          on_hs = (ps == PS_HS_ADDR);
          r.handshake_part = on_hs;
          r.byte_role = ROLE_ADDR;
          r.pass_byte = b;
          // track the ::ffff prefix of a mapped address
          if (kind_q == KIND_V6) begin
            if (fld_cnt < MAP_ZERO_END) begin
              if (b != 8'h00) map_ok = 1'b0;
            end else if (fld_cnt < MAP_FF_END) begin
              if (b != MAP_FF_BYTE) map_ok = 1'b0;
            end
          end
          fld_cnt = fld_cnt + 16'd1;
          if (fld_cnt >= {8'h00, fld_need}) begin
            if (kind_q == KIND_V6) r.addr_mapped_v4 = map_ok;
            fld_cnt = 16'h0;
            fld_need = 8'h00;
            ps = on_hs ? PS_HS_PORT : PS_PKT_PORT;
          end
        end
        PS_HS_DLEN, PS_PKT_DLEN: begin
          on_hs = (ps == PS_HS_DLEN);
          r.handshake_part = on_hs;
          if (b == 8'h00) begin
            err_latched = 1'b1;
            err_code = ERR_EMPTY;
            r.error_code = ERR_EMPTY;
          end else begin
            fld_need = b;
            fld_cnt = 16'h0;
            ps = on_hs ? PS_HS_DOM : PS_PKT_DOM;
          end
        end
        PS_HS_DOM, PS_PKT_DOM: begin
          on_hs = (ps == PS_HS_DOM);
          r.handshake_part = on_hs;
          r.byte_role = ROLE_ADDR;
          r.pass_byte = b;
          fld_cnt = fld_cnt + 16'd1;
          if (fld_cnt >= {8'h00, fld_need}) begin
            fld_cnt = 16'h0;
            fld_need = 8'h00;
            ps = on_hs ? PS_HS_PORT : PS_PKT_PORT;
          end
        end
        PS_HS_PORT, PS_PKT_PORT: begin
          on_hs = (ps == PS_HS_PORT);
          r.handshake_part = on_hs;
          // first port byte parks in the need register
          if (fld_cnt == 16'h0) begin
            fld_need = b;
            fld_cnt = 16'd1;
          end else begin
            port_q = {fld_need, b};
            fld_cnt = 16'h0;
            fld_need = 8'h00;
            if (on_hs) r.frame_done = 1'b1;
            else pkt_addr_seen = 1'b1;
            ps = PS_LEN_HI;
          end
        end
        PS_LEN_HI: begin
          // without connect, a frame opens with its packet address
          if (!conn_flag && !pkt_addr_seen) begin
            r.error_code = take_addr_type(b, 1'b0);
          end else begin
            len_q = {b, 8'h00};
            ps = PS_LEN_LO;
          end
        end
        PS_LEN_LO: begin
          len_q = len_q | {8'h00, b};
          fld_cnt = 16'h0;
          fld_need = 8'h00;
          if (len_q == 16'h0) begin
            r.frame_done = 1'b1;
            pkt_addr_seen = 1'b0;
            ps = PS_LEN_HI;
          end else begin
            ps = PS_DATA;
          end
        end
        PS_DATA: begin
          r.byte_role = ROLE_DATA;
          r.pass_byte = b;
          fld_cnt = fld_cnt + 16'd1;
          if (fld_cnt >= len_q) begin
            r.frame_done = 1'b1;
            pkt_addr_seen = 1'b0;
            fld_cnt = 16'h0;
            ps = PS_LEN_HI;
          end
        end
        default: begin
          // connect flag byte
          r.handshake_part = 1'b1;
          conn_flag = (b != 8'h00);
          fld_cnt = 16'h0;
          fld_need = 8'h00;
          ps = PS_HS_ATYPE;
        end
      endcase
    end
    r.addr_kind = kind_q;
    r.connect_mode = conn_flag;
    r.dest_port = port_q;
    r.frame_length = len_q;
    return r;
  endfunction

  // offer one byte, with random idle cycles ahead of it
  task automatic send_byte(input byte_t b);
    deframe_res_t expected;
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    expected = deframe_byte(b);
    pending_results.insert(pending_results.size(), expected);
    items_sent++;
  endtask

  // random address of any kind followed by a random port
  task automatic send_endpoint(input logic hs);
    int unsigned k, form, pos, dlen;
    byte_t v6 [16];
    k = $urandom_range(2);
    if (k == 0) begin
      send_byte(hs ? HS_ATYPE_V4 : PKT_ATYPE_V4);
      repeat (4) send_byte(byte_t'($urandom));
    end else if (k == 1) begin
      send_byte(hs ? HS_ATYPE_V6 : PKT_ATYPE_V6);
      foreach (v6[i]) v6[i] = byte_t'($urandom);
      // mapped, almost mapped, or plain random
      form = $urandom_range(3);
      if (form < 2) begin
        for (int i = 0; i < 10; i++) v6[i] = 8'h00;
        v6[10] = MAP_FF_BYTE;
        v6[11] = MAP_FF_BYTE;
        if (form == 1) begin
          pos = $urandom_range(11);
          v6[pos] = (pos < 10) ? byte_t'($urandom_range(255, 1))
                               : byte_t'($urandom_range(254, 0));
        end
      end
      foreach (v6[i]) send_byte(v6[i]);
    end else begin
      send_byte(hs ? HS_ATYPE_DOM : PKT_ATYPE_DOM);
      dlen = ($urandom_range(19) == 0) ? 255 : $urandom_range(12, 1);
      send_byte(byte_t'(dlen));
      repeat (dlen) send_byte(byte_t'($urandom));
    end
    send_byte(byte_t'($urandom));
    send_byte(byte_t'($urandom));
  endtask

  // one well-formed data frame with random content
  task automatic send_frame();
    int unsigned len, pick;
    if (!gen_conn) send_endpoint(1'b0);
    pick = $urandom_range(99);
    if (pick < 10) len = 0;
    else if (pick < 85) len = $urandom_range(16, 1);
    else if (pick < 97) len = $urandom_range(64, 17);
    else len = $urandom_range(300, 256);
    send_byte(byte_t'(len >> 8));
    send_byte(byte_t'(len));
    repeat (len) send_byte(byte_t'($urandom));
  endtask

  // connect flag and handshake address; now and then a bad one
  task automatic test_handshake();
    byte_t b;
    b = $urandom_range(1) ? 8'h00 : byte_t'($urandom_range(255, 1));
    gen_conn = (b != 8'h00);
    send_byte(b);
    if ($urandom_range(15) == 0) begin
      if ($urandom_range(1)) begin
        send_byte(HS_ATYPE_DOM);
        send_byte(8'h00);
      end else begin
        do b = byte_t'($urandom);
        while (b == HS_ATYPE_V4 || b == HS_ATYPE_V6 || b == HS_ATYPE_DOM);
        send_byte(b);
      end
    end else begin
      send_endpoint(1'b1);
    end
  endtask

  // empty and short frames, or without connect a v4 address with port zero
  task automatic test_frame_basics();
    if (!gen_conn) begin
      send_byte(PKT_ATYPE_V4);
      send_byte(8'h00);
      send_byte(8'hff);
      send_byte(8'h80);
      send_byte(8'h7f);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(PKT_ATYPE_DOM);
      send_byte(8'h01);
      send_byte(byte_t'($urandom));
      send_byte(8'hff);
      send_byte(8'hff);
    end else begin
      send_byte(8'h00);
      send_byte(8'h00);
    end
    send_byte(8'h00);
    send_byte(8'h02);
    send_byte(8'hff);
    send_byte(8'h00);
  endtask

  // random frames until about n more items have gone in
  task automatic test_random_stream(input int unsigned n);
    int unsigned target;
    target = items_sent + n;
    while (items_sent < target) send_frame();
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_receiver_holdoff();
    idle_pct = 0;
    stall_pct = 0;
    send_frame();
    hold_req = 1'b1;
    test_random_stream(100);
  endtask

  // without connect, force a sticky error, then check that later bytes are refused
  task automatic test_sticky_error();
    byte_t b;
    if (gen_conn) begin
      // no packet address here: open a maximum length frame instead
      send_byte(8'hff);
      send_byte(8'hff);
    end else if ($urandom_range(1)) begin
      b = byte_t'($urandom_range(255, 3));
      send_byte(b);
    end else begin
      send_byte(PKT_ATYPE_DOM);
      send_byte(8'h00);
    end
    repeat (8) send_byte(byte_t'($urandom));
  endtask

  // receiver ready, with random stalls and one long hold-off
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      res_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic void compare_field(string name, logic [15:0] want,
                                        logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // compare each result item with the oldest prediction
  always @(posedge clk) begin
    deframe_res_t want;
    if (!rst && res_valid && res_ready) begin
      if (pending_results.size() == 0) begin
        $error("result item with no input item pending");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        compare_field("accepted", 16'(want.accepted), 16'(accepted));
        compare_field("byte_role", 16'(want.byte_role), 16'(byte_role));
        compare_field("pass_byte", 16'(want.pass_byte), 16'(pass_byte));
        compare_field("addr_kind", 16'(want.addr_kind), 16'(addr_kind));
        compare_field("addr_mapped_v4", 16'(want.addr_mapped_v4),
                      16'(addr_mapped_v4));
        compare_field("connect_mode", 16'(want.connect_mode), 16'(connect_mode));
        compare_field("dest_port", want.dest_port, dest_port);
        compare_field("frame_length", want.frame_length, frame_length);
        compare_field("frame_done", 16'(want.frame_done), 16'(frame_done));
        compare_field("handshake_part", 16'(want.handshake_part),
                      16'(handshake_part));
        compare_field("error_code", 16'(want.error_code), 16'(error_code));
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (res_valid && res_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("uot_stream_deframer: mismatch");
      $finish;
    end
  end

  initial begin : run
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_handshake();
    test_frame_basics();
    test_receiver_holdoff();
    idle_pct = 0;
    stall_pct = 0;
    test_random_stream(100);
    idle_pct = 64;
    stall_pct = 0;
    test_random_stream(120);
    idle_pct = 0;
    stall_pct = 64;
    test_random_stream(120);
    idle_pct = 21;
    stall_pct = 21;
    test_random_stream(120);
    test_sticky_error();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("uot_stream_deframer: match");
    end else begin
      $display("uot_stream_deframer: mismatch");
    end
    $finish;
  end

endmodule
